>>> design/b64_pkg.sv
// Shared types, constants and lookup functions for the Base64 codec.
package b64_pkg;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    localparam logic [1:0] STAT_OK         = 2'd0;
    localparam logic [1:0] STAT_INVALID    = 2'd1;
    localparam logic [1:0] STAT_INCOMPLETE = 2'd2;

    localparam logic [7:0] CHAR_PAD   = 8'h3D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;

    localparam int JOB_DEPTH = 2;
    localparam int JOB_AW    = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
    localparam int JOB_CW    = $clog2(JOB_DEPTH + 1);

    localparam logic [JOB_CW-1:0] JOB_FULL = JOB_CW'(JOB_DEPTH);
    localparam logic [JOB_AW-1:0] JOB_LAST = JOB_AW'(JOB_DEPTH - 1);

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } b64_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_run_last;
        logic       out_stream_end;
        logic [1:0] out_status;
    } b64_out_t;

    typedef enum logic [1:0] {
        JOB_ENC,
        JOB_DEC,
        JOB_INC
    } job_kind_t;

    // cnt: encode = characters minus one, decode = bytes minus one
    typedef struct packed {
        job_kind_t   kind;
        logic [23:0] bits;
        logic [1:0]  cnt;
        logic        last;
        logic        invalid;
    } job_t;

    function automatic logic [7:0] sextet_char(input logic [5:0] s);
        logic [7:0] c;
        c = CHAR_SLASH;
        if (s < 6'd26)
            c = 8'h41 + {2'b00, s};
        else if (s < 6'd52)
            c = 8'h61 + {2'b00, s - 6'd26};
        else if (s < 6'd62)
            c = 8'h30 + {2'b00, s - 6'd52};
        else if (s == 6'd62)
            c = CHAR_PLUS;
        return c;
    endfunction

    // bit 6 set: character is in the alphabet
    function automatic logic [6:0] char_sextet(input logic [7:0] c);
        logic [6:0] r;
        r = 7'd0;
        if (c inside {[8'h41:8'h5A]})
            r = {1'b1, 6'(c - 8'h41)};
        else if (c inside {[8'h61:8'h7A]})
            r = {1'b1, 6'(c - 8'h61 + 8'd26)};
        else if (c inside {[8'h30:8'h39]})
            r = {1'b1, 6'(c - 8'h30 + 8'd52)};
        else if (c == CHAR_PLUS)
            r = {1'b1, 6'd62};
        else if (c == CHAR_SLASH)
            r = {1'b1, 6'd63};
        return r;
    endfunction

endpackage

>>> design/b64_front.sv
// Front end: mode register, group gathering and job generation.
module b64_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    input  logic              cfg_data,
    input  logic              accept,
    input  b64_pkg::b64_in_t  data,
    output logic              job_push,
    output b64_pkg::job_t     job
);

    logic        mode_reg;
    logic [23:0] bits_reg, bits_next;
    logic [1:0]  count_reg, count_next;
    logic        twp_reg, twp_next;
    logic        inv_reg, inv_next;

    logic [1:0]  ne;
    logic [2:0]  n1;
    logic [23:0] base;
    logic [23:0] merged;
    logic        pad;
    logic [6:0]  lookup;
    logic [5:0]  sx;
    logic        inv_cur;
    logic        emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= b64_pkg::MODE_ENCODE;
            bits_reg  <= '0;
            count_reg <= '0;
            twp_reg   <= 1'b0;
            inv_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                mode_reg <= cfg_data;
            bits_reg  <= bits_next;
            count_reg <= count_next;
            twp_reg   <= twp_next;
            inv_reg   <= inv_next;
        end
    end

    always_comb
    begin
        bits_next  = bits_reg;
        count_next = count_reg;
        twp_next   = twp_reg;
        inv_next   = inv_reg;
        job_push   = 1'b0;
        job        = '0;
        emit       = 1'b0;
        pad        = (data.in_byte == b64_pkg::CHAR_PAD);
        lookup     = b64_pkg::char_sextet(data.in_byte);
        sx         = (!pad && lookup[6]) ? lookup[5:0] : 6'd0;
        inv_cur    = inv_reg | (!pad && !lookup[6]);
        ne         = 2'd0;
        n1         = 3'd0;
        base       = '0;
        merged     = '0;

        if (mode_reg == b64_pkg::MODE_ENCODE)
        begin
            ne   = (count_reg == 2'd3) ? 2'd0 : count_reg;
            base = (ne == 2'd0) ? 24'd0 : bits_reg;
            case (ne)
                2'd0:    merged = {data.in_byte, 16'd0};
                2'd1:    merged = base | {8'd0, data.in_byte, 8'd0};
                default: merged = base | {16'd0, data.in_byte};
            endcase
            n1   = {1'b0, ne} + 3'd1;
            emit = (n1 == 3'd3) || data.in_last;
            if (accept)
            begin
                if (emit)
                begin
                    job_push    = 1'b1;
                    job.kind    = b64_pkg::JOB_ENC;
                    job.bits    = merged;
                    job.cnt     = n1[1:0];
                    job.last    = data.in_last;
                    job.invalid = 1'b0;
                    bits_next   = '0;
                    count_next  = '0;
                    twp_next    = 1'b0;
                    inv_next    = 1'b0;
                end
                else
                begin
                    bits_next  = merged;
                    count_next = n1[1:0];
                end
            end
        end
        else
        begin
            base = (count_reg == 2'd0) ? 24'd0 : bits_reg;
            case (count_reg)
                2'd0:    merged = {sx, 18'd0};
                2'd1:    merged = base | {6'd0, sx, 12'd0};
                2'd2:    merged = base | {12'd0, sx, 6'd0};
                default: merged = base | {18'd0, sx};
            endcase
            if (accept)
            begin
                if (count_reg != 2'd3)
                begin
                    if (data.in_last)
                    begin
                        job_push    = 1'b1;
                        job.kind    = b64_pkg::JOB_INC;
                        job.bits    = '0;
                        job.cnt     = 2'd0;
                        job.last    = 1'b1;
                        job.invalid = 1'b0;
                        bits_next   = '0;
                        count_next  = '0;
                        twp_next    = 1'b0;
                        inv_next    = 1'b0;
                    end
                    else
                    begin
                        bits_next  = merged;
                        count_next = count_reg + 2'd1;
                        inv_next   = inv_cur;
                        if (count_reg == 2'd2)
                            twp_next = pad;
                    end
                end
                else
                begin
                    job_push    = 1'b1;
                    job.kind    = b64_pkg::JOB_DEC;
                    job.bits    = merged;
                    job.cnt     = 2'd2 - {1'b0, data.in_last & pad}
                                       - {1'b0, data.in_last & twp_reg};
                    job.last    = data.in_last;
                    job.invalid = inv_cur;
                    bits_next   = '0;
                    count_next  = '0;
                    twp_next    = 1'b0;
                    inv_next    = 1'b0;
                end
            end
        end
    end

endmodule

>>> design/b64_fifo.sv
// Short job queue between the front end and the result sequencer.
module b64_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  b64_pkg::job_t  wr_job,
    input  logic           rd_en,
    output logic           rd_valid,
    output b64_pkg::job_t  rd_job,
    output logic           q_full
);

    b64_pkg::job_t                  mem [b64_pkg::JOB_DEPTH];
    logic [b64_pkg::JOB_AW-1:0]     wptr_reg, rptr_reg;
    logic [b64_pkg::JOB_CW-1:0]     cnt_reg;
    logic                           do_wr, do_rd;

    assign q_full   = (cnt_reg == b64_pkg::JOB_FULL);
    assign rd_valid = (cnt_reg != '0);
    assign rd_job   = mem[rptr_reg];
    assign do_wr    = wr_en && !q_full;
    assign do_rd    = rd_en && rd_valid;

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wptr_reg] <= wr_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wptr_reg <= (wptr_reg == b64_pkg::JOB_LAST) ? '0 : wptr_reg + 1'b1;
            if (do_rd)
                rptr_reg <= (rptr_reg == b64_pkg::JOB_LAST) ? '0 : rptr_reg + 1'b1;
            if (do_wr && !do_rd)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_rd && !do_wr)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

>>> design/b64_back.sv
// Back end: expands each job into result items through the output register.
module b64_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    input  b64_pkg::job_t     job,
    output logic              job_pop,
    input  logic              pop,
    output logic              empty,
    output b64_pkg::b64_out_t result
);

    logic [1:0]         idx_reg;
    logic               ov_reg;
    b64_pkg::b64_out_t  res_reg;
    b64_pkg::b64_out_t  res_next;
    logic [1:0]         fin;
    logic               adv;
    logic [5:0]         sx;
    logic [7:0]         byt;

    assign empty  = !ov_reg;
    assign result = res_reg;
    assign adv    = job_valid && (!ov_reg || pop);

    always_comb
    begin
        case (idx_reg)
            2'd0:    sx = job.bits[23:18];
            2'd1:    sx = job.bits[17:12];
            2'd2:    sx = job.bits[11:6];
            default: sx = job.bits[5:0];
        endcase
        case (idx_reg)
            2'd0:    byt = job.bits[23:16];
            2'd1:    byt = job.bits[15:8];
            default: byt = job.bits[7:0];
        endcase

        res_next = '0;
        fin      = 2'd0;
        case (job.kind)
            b64_pkg::JOB_ENC:
            begin
                fin = 2'd3;
                res_next.out_byte       = (idx_reg <= job.cnt) ? b64_pkg::sextet_char(sx)
                                                               : b64_pkg::CHAR_PAD;
                res_next.out_run_last   = (idx_reg == fin);
                res_next.out_stream_end = job.last && (idx_reg == fin);
                res_next.out_status     = b64_pkg::STAT_OK;
            end
            b64_pkg::JOB_DEC:
            begin
                fin = job.cnt;
                res_next.out_byte       = byt;
                res_next.out_run_last   = (idx_reg == fin);
                res_next.out_stream_end = job.last && (idx_reg == fin);
                res_next.out_status     = job.invalid ? b64_pkg::STAT_INVALID
                                                      : b64_pkg::STAT_OK;
            end
            default:
            begin
                fin = 2'd0;
                res_next.out_byte       = 8'd0;
                res_next.out_run_last   = 1'b1;
                res_next.out_stream_end = 1'b1;
                res_next.out_status     = b64_pkg::STAT_INCOMPLETE;
            end
        endcase
        job_pop = adv && (idx_reg == fin);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                ov_reg  <= 1'b1;
                idx_reg <= (idx_reg == fin) ? 2'd0 : idx_reg + 2'd1;
            end
            else if (pop)
                ov_reg <= 1'b0;
        end
    end

endmodule

>>> design/base64_codec.sv
// Top level of the streaming Base64 codec.
// Usage:
//   Input queue side: drive data (in_byte, in_last) with push; an item is
//   taken when push is high and full is low. in_last closes the stream.
//   Result queue side: while empty is low, result holds the oldest result;
//   pop takes it. Each result is one byte with run-last, stream-end and
//   status flags.
//   Config: cfg_valid writes cfg_data into the mode bit (0 encode,
//   1 decode); cfg_ready is always high. Write only while the codec is idle.
// Timing:
//   Input is taken one item per cycle while the two-entry job queue has room.
//   The closing item forms a job; the job queue feeds the output register.
//   Results leave at one per cycle from the output register while pop
//   keeps it drained, so encoding sustains four results per three input
//   bytes; decoding sustains three results per four input characters.
// Reset clears the group state and the job queue, marks the output
// register empty and selects encode mode. A stalled receiver fills the
// output register and the job queue, after which full rises and input waits.
module base64_codec (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  b64_pkg::b64_in_t  data,
    output logic              empty,
    input  logic              pop,
    output b64_pkg::b64_out_t result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_data
);

    logic           accept;
    logic           job_push;
    b64_pkg::job_t  job_in;
    logic           job_valid;
    b64_pkg::job_t  job_head;
    logic           job_pop;
    logic           q_full;

    assign full      = q_full;
    assign accept    = push && !q_full;
    assign cfg_ready = 1'b1;

    b64_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .data      (data),
        .job_push  (job_push),
        .job       (job_in)
    );

    b64_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (job_push),
        .wr_job   (job_in),
        .rd_en    (job_pop),
        .rd_valid (job_valid),
        .rd_job   (job_head),
        .q_full   (q_full)
    );

    b64_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (job_head),
        .job_pop   (job_pop),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

endmodule
